// File: src/fbtp_pkg.sv
// Package for the five-bit text packer.
// Holds the character set constants, the code and result types.
// No dependencies.
package fbtp_pkg;

	localparam int CodeWidth  = 5;
	localparam int ByteWidth  = 8;
	localparam int CountWidth = 3;
	localparam int PendWidth  = 7;
	localparam int AccWidth   = PendWidth + CodeWidth;

	// Command codes on the request channel
	localparam logic CmdChar  = 1'b0;
	localparam logic CmdFlush = 1'b1;

	// Accepted character bytes
	localparam logic [ByteWidth-1:0] CharLowA   = 8'h61;
	localparam logic [ByteWidth-1:0] CharLowZ   = 8'h7a;
	localparam logic [ByteWidth-1:0] CharSpace  = 8'h20;
	localparam logic [ByteWidth-1:0] CharComma  = 8'h2c;
	localparam logic [ByteWidth-1:0] CharPeriod = 8'h2e;
	localparam logic [ByteWidth-1:0] CharQuery  = 8'h3f;
	localparam logic [ByteWidth-1:0] CharQuote  = 8'h22;
	localparam logic [ByteWidth-1:0] CharBang   = 8'h21;

	// Symbol codes above the letters
	localparam logic [CodeWidth-1:0] CodeSpace  = 5'd26;
	localparam logic [CodeWidth-1:0] CodeComma  = 5'd27;
	localparam logic [CodeWidth-1:0] CodePeriod = 5'd28;
	localparam logic [CodeWidth-1:0] CodeQuery  = 5'd29;
	localparam logic [CodeWidth-1:0] CodeQuote  = 5'd30;
	localparam logic [CodeWidth-1:0] CodeBang   = 5'd31;

	// Mapped character: hit flag and 5-bit code
	typedef struct packed {
		logic                 hit;
		logic [CodeWidth-1:0] code;
	} fbtp_code_t;

	// One result on the byte channel
	typedef struct packed {
		logic [ByteWidth-1:0]  data_byte;
		logic                  byte_present;
		logic                  last;
		logic [CountWidth-1:0] pad_bits;
	} fbtp_result_t;

endpackage

// File: src/fbtp_char_map.sv
// Character mapper for the five-bit text packer.
// Turns a raw character byte into a 5-bit code, or flags it as dropped.
// Depends on fbtp_pkg.
module fbtp_char_map (
	input  logic [7:0]          char_code,
	output fbtp_pkg::fbtp_code_t mapped
);
	import fbtp_pkg::*;

	// Letters by offset, symbols by table
	always_comb begin
		mapped = '0;
		case (char_code) inside
			[CharLowA:CharLowZ]: begin
				mapped.hit  = 1'b1;
				mapped.code = CodeWidth'(char_code - CharLowA);
			end
			CharSpace: begin
				mapped.hit  = 1'b1;
				mapped.code = CodeSpace;
			end
			CharComma: begin
				mapped.hit  = 1'b1;
				mapped.code = CodeComma;
			end
			CharPeriod: begin
				mapped.hit  = 1'b1;
				mapped.code = CodePeriod;
			end
			CharQuery: begin
				mapped.hit  = 1'b1;
				mapped.code = CodeQuery;
			end
			CharQuote: begin
				mapped.hit  = 1'b1;
				mapped.code = CodeQuote;
			end
			CharBang: begin
				mapped.hit  = 1'b1;
				mapped.code = CodeBang;
			end
			default: begin
				mapped = '0;
			end
		endcase
	end

endmodule

// File: src/fbtp_pack.sv
// Bit accumulator for the five-bit text packer.
// Holds the leftover bits, forms each result and updates on every taken request.
// Depends on fbtp_pkg.
module fbtp_pack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic                   cmd,
	input  fbtp_pkg::fbtp_code_t   mapped,
	output logic                   res_valid,
	output fbtp_pkg::fbtp_result_t res
);
	import fbtp_pkg::*;

	logic [PendWidth-1:0]  pending_bits_q;
	logic [CountWidth-1:0] pending_count_q;

	logic [AccWidth-1:0]   acc;
	logic [CountWidth:0]   cnt_sum;
	logic [CountWidth-1:0] cnt_left;
	logic [AccWidth-1:0]   keep_mask;
	logic [CountWidth-1:0] pad;
	logic [PendWidth-1:0]  bits_nxt;
	logic [CountWidth-1:0] count_nxt;
	logic                  upd;

	// Accumulate the new code below the pending bits
	assign acc       = {pending_bits_q, mapped.code};
	assign cnt_sum   = {1'b0, pending_count_q} + (CountWidth+1)'(CodeWidth);
	assign cnt_left  = cnt_sum[CountWidth-1:0];
	assign keep_mask = (AccWidth'(1) << cnt_left) - AccWidth'(1);
	assign pad       = CountWidth'(0) - pending_count_q;

	// Result and next state
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		bits_nxt  = pending_bits_q;
		count_nxt = pending_count_q;
		upd       = 1'b0;
		if (cmd == CmdFlush) begin
			upd              = 1'b1;
			res_valid        = 1'b1;
			res.last         = 1'b1;
			res.pad_bits     = pad;
			res.byte_present = (pending_count_q != '0);
			res.data_byte    = (pending_count_q != '0) ?
				ByteWidth'({1'b0, pending_bits_q} << pad) : '0;
			bits_nxt         = '0;
			count_nxt        = '0;
		end else if (mapped.hit) begin
			upd = 1'b1;
			if (cnt_sum[CountWidth]) begin
				// A full byte has gathered
				res_valid        = 1'b1;
				res.byte_present = 1'b1;
				res.data_byte    = ByteWidth'(acc >> cnt_left);
				bits_nxt         = PendWidth'(acc & keep_mask);
				count_nxt        = cnt_left;
			end else begin
				bits_nxt  = PendWidth'(acc);
				count_nxt = cnt_left;
			end
		end
	end

	// Leftover bit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_bits_q  <= '0;
			pending_count_q <= '0;
		end else if (take && upd) begin
			pending_bits_q  <= bits_nxt;
			pending_count_q <= count_nxt;
		end
	end

	// Bits above the fill count stay clear
	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_bits_q >> pending_count_q) == '0)
		else $error("pending bits above count not clear");

	// A taken flush empties the accumulator
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd == CmdFlush) |=> (pending_count_q == '0 && pending_bits_q == '0))
		else $error("flush did not clear accumulator");

	// A byte comes out only when the count reaches eight, leaving fewer than five bits
	a_byte_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd == CmdChar && mapped.hit && res_valid) |=>
		(pending_count_q < CountWidth'(CodeWidth)))
		else $error("count after byte out of range");

endmodule

// File: src/five_bit_text_packer.sv
// Top level of the five-bit text packer.
// Request register, character mapper, accumulator and result register.
// Depends on fbtp_pkg, fbtp_char_map and fbtp_pack.
//
// Takes one request per cycle while char_stall is low: a character
// (cmd = 0) or an end-of-message flush (cmd = 1). Letters a-z and the
// symbols space , . ? " ! are packed as 5-bit codes, most significant
// bit first; any other byte is dropped and gives no result. A result
// is given whenever eight bits have gathered, and on every flush (with
// the leftover bits left-aligned and pad_bits set, last = 1). A request
// passes from the request register through the mapper and accumulator,
// which updates its leftover-bit register, into the result register
// that drives byte_valid. The result register holds while byte_stall
// is high, and one further request may wait in the request register
// before char_stall rises.
module five_bit_text_packer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic       cmd,
	input  logic [7:0] char_code,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] data_byte,
	output logic       byte_present,
	output logic       last,
	output logic [2:0] pad_bits
);
	import fbtp_pkg::*;

	logic                 valid_s1;
	logic                 cmd_s1;
	logic [ByteWidth-1:0] char_s1;
	logic                 out_valid_q;
	fbtp_result_t         res_q;
	fbtp_code_t           mapped;
	fbtp_result_t         res;
	logic                 res_valid;
	logic                 advance;
	logic                 take;

	// Stage moves when the result register is free or being emptied
	assign advance    = !out_valid_q || !byte_stall;
	assign take       = valid_s1 && advance;
	assign char_stall = valid_s1 && !advance;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			cmd_s1  <= cmd;
			char_s1 <= char_code;
		end
	end

	fbtp_char_map u_map (
		.char_code (char_s1),
		.mapped    (mapped)
	);

	fbtp_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cmd       (cmd_s1),
		.mapped    (mapped),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_q <= res;
		end
	end

	assign byte_valid   = out_valid_q;
	assign data_byte    = res_q.data_byte;
	assign byte_present = res_q.byte_present;
	assign last         = res_q.last;
	assign pad_bits     = res_q.pad_bits;

	// Mid-message results always carry a full byte and no pad
	a_mid_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.last) |-> (res_q.byte_present && res_q.pad_bits == '0))
		else $error("mid-message result without full byte");

	// Empty flush gives a zero byte and no pad
	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.last && !res_q.byte_present) |->
		(res_q.data_byte == '0 && res_q.pad_bits == '0))
		else $error("empty flush result not zero");

	// A taken flush request always lands in the result register
	a_flush_out: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd_s1 == CmdFlush) |=> (out_valid_q && res_q.last))
		else $error("flush result missing");

endmodule
